### src/kfpv_pkg.sv
// Package for the two-state position/velocity Kalman filter.
// Holds fixed-point formats, codes, micro-program ROM and saturating helpers.
// No dependencies.
`default_nettype none

package kfpv_pkg;

    localparam int VALUE_FRAC_BITS = 16;
    localparam int COV_FRAC_BITS   = 24;
    localparam int COV_WIDTH       = 48;
    localparam int WIDE            = 64;
    localparam int CONV_SHIFT      = COV_FRAC_BITS - VALUE_FRAC_BITS;
    localparam int DIV_BITS        = WIDE + COV_FRAC_BITS;
    localparam int DIV_CNT_W       = $clog2(DIV_BITS);
    localparam int PC_W            = 7;

    localparam logic signed [WIDE-1:0] WIDE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [WIDE-1:0] WIDE_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [WIDE-1:0] ONE_COV  = 64'sd1 <<< COV_FRAC_BITS;
    localparam logic signed [WIDE-1:0] VAL_MAX  = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [WIDE-1:0] VAL_MIN  = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [WIDE-1:0] COV_MAX  = (64'sd1 <<< (COV_WIDTH - 1)) - 64'sd1;
    localparam logic signed [WIDE-1:0] COV_MIN  = -COV_MAX - 64'sd1;
    localparam logic signed [COV_WIDTH-1:0] COV_INIT =
        COV_WIDTH'(64'sd1000 <<< COV_FRAC_BITS);

    // Input operation codes
    localparam logic [1:0] OP_PREDICT = 2'd0;
    localparam logic [1:0] OP_CORRECT = 2'd1;
    localparam logic [1:0] OP_RESET   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_DT = 3'd0;
    localparam logic [2:0] CFG_QA = 3'd1;
    localparam logic [2:0] CFG_RN = 3'd2;
    localparam logic [2:0] CFG_GS = 3'd3;
    localparam logic [2:0] CFG_JM = 3'd4;

    typedef enum logic [3:0] {
        U_END  = 4'd0,
        U_MUL  = 4'd1,
        U_DIV  = 4'd2,
        U_ADD  = 4'd3,
        U_SUB  = 4'd4,
        U_NEG  = 4'd5,
        U_SHR1 = 4'd6,
        U_SHR2 = 4'd7,
        U_MAX1 = 4'd8,
        U_STX  = 4'd9,
        U_STP  = 4'd10,
        U_BGZ  = 4'd11,
        U_BJ0  = 4'd12,
        U_JMP  = 4'd13,
        U_GATE = 4'd14
    } t_uop;

    typedef logic [4:0] t_src;

    // Scratch registers
    localparam t_src W0 = 5'd0,  W1 = 5'd1,  W2 = 5'd2,  W3 = 5'd3;
    localparam t_src W4 = 5'd4,  W5 = 5'd5,  W6 = 5'd6,  W7 = 5'd7;
    localparam t_src W8 = 5'd8,  W9 = 5'd9,  W10 = 5'd10, W11 = 5'd11;
    localparam t_src W12 = 5'd12, W13 = 5'd13, W14 = 5'd14, W15 = 5'd15;
    // Operands taken from config, state or input, in covariance format
    localparam t_src S_DT  = 5'd16, S_QA  = 5'd17, S_RN  = 5'd18, S_GS  = 5'd19;
    localparam t_src S_XP  = 5'd20, S_XV  = 5'd21, S_Z   = 5'd22, S_P00 = 5'd23;
    localparam t_src S_P01 = 5'd24, S_P10 = 5'd25, S_P11 = 5'd26, S_ONE = 5'd27;
    // Store targets
    localparam t_src D_POS = 5'd0, D_VEL = 5'd1;
    localparam t_src D_P00 = 5'd0, D_P01 = 5'd1, D_P10 = 5'd2, D_P11 = 5'd3;

    localparam logic [PC_W-1:0] PC_PREDICT = 7'd0;
    localparam logic [PC_W-1:0] PC_CORRECT = 7'd34;
    localparam logic [PC_W-1:0] PC_KGAIN   = 7'd42;
    localparam logic [PC_W-1:0] PC_STORE   = 7'd75;
    localparam logic [PC_W-1:0] PC_STD     = 7'd80;

    typedef struct packed {
        t_uop            op;
        t_src            dst;
        t_src            a;
        t_src            b;
        logic [PC_W-1:0] tgt;
    } t_uins;

    typedef struct packed {
        logic signed [WIDE-1:0] v;
        logic                   clip;
    } t_res;

    function automatic t_uins mk(t_uop op, t_src d, t_src a, t_src b);
        t_uins u;
        u.op  = op;
        u.dst = d;
        u.a   = a;
        u.b   = b;
        u.tgt = '0;
        return u;
    endfunction

    function automatic t_uins mkj(t_uop op, logic [PC_W-1:0] tgt);
        t_uins u;
        u     = mk(op, W0, W0, W0);
        u.tgt = tgt;
        return u;
    endfunction

    // Micro-program: predict, then correct with Joseph and standard tails
    function automatic t_uins f_prog(logic [PC_W-1:0] pc);
        t_uins u;
        case (pc)
            // predict
            7'd0:  u = mk(U_MUL,  W0,  S_DT,  S_DT);
            7'd1:  u = mk(U_MUL,  W1,  W0,    S_DT);
            7'd2:  u = mk(U_MUL,  W2,  W0,    W0);
            7'd3:  u = mk(U_MUL,  W3,  W2,    S_QA);
            7'd4:  u = mk(U_SHR2, W3,  W3,    W3);
            7'd5:  u = mk(U_MUL,  W4,  W1,    S_QA);
            7'd6:  u = mk(U_SHR1, W4,  W4,    W4);
            7'd7:  u = mk(U_MUL,  W5,  W0,    S_QA);
            7'd8:  u = mk(U_SHR1, W6,  W0,    W0);
            7'd9:  u = mk(U_MUL,  W7,  S_DT,  S_XV);
            7'd10: u = mk(U_ADD,  W7,  S_XP,  W7);
            7'd11: u = mk(U_MUL,  W8,  W6,    S_Z);
            7'd12: u = mk(U_ADD,  W7,  W7,    W8);
            7'd13: u = mk(U_MUL,  W8,  S_DT,  S_Z);
            7'd14: u = mk(U_ADD,  W8,  S_XV,  W8);
            7'd15: u = mk(U_STX,  D_POS, W7,  W7);
            7'd16: u = mk(U_STX,  D_VEL, W8,  W8);
            7'd17: u = mk(U_MUL,  W9,  S_DT,  S_P10);
            7'd18: u = mk(U_ADD,  W9,  S_P00, W9);
            7'd19: u = mk(U_MUL,  W10, S_DT,  S_P11);
            7'd20: u = mk(U_ADD,  W10, S_P01, W10);
            7'd21: u = mk(U_MUL,  W11, W10,   S_DT);
            7'd22: u = mk(U_ADD,  W11, W9,    W11);
            7'd23: u = mk(U_ADD,  W11, W11,   W3);
            7'd24: u = mk(U_ADD,  W12, W10,   W4);
            7'd25: u = mk(U_MUL,  W13, S_P11, S_DT);
            7'd26: u = mk(U_ADD,  W13, S_P10, W13);
            7'd27: u = mk(U_ADD,  W13, W13,   W4);
            7'd28: u = mk(U_ADD,  W14, S_P11, W5);
            7'd29: u = mk(U_STP,  D_P00, W11, W11);
            7'd30: u = mk(U_STP,  D_P01, W12, W12);
            7'd31: u = mk(U_STP,  D_P10, W13, W13);
            7'd32: u = mk(U_STP,  D_P11, W14, W14);
            7'd33: u = mkj(U_END, '0);
            // correct: innovation, S and optional gate
            7'd34: u = mk(U_SUB,  W0,  S_Z,   S_XP);
            7'd35: u = mk(U_ADD,  W1,  S_P00, S_RN);
            7'd36: u = mk(U_MAX1, W1,  W1,    W1);
            7'd37: u = mkj(U_BGZ, PC_KGAIN);
            7'd38: u = mk(U_MUL,  W2,  W0,    W0);
            7'd39: u = mk(U_MUL,  W3,  S_GS,  S_GS);
            7'd40: u = mk(U_MUL,  W3,  W3,    W1);
            7'd41: u = mk(U_GATE, W0,  W2,    W3);
            // gain and state update
            7'd42: u = mk(U_DIV,  W4,  S_P00, W1);
            7'd43: u = mk(U_DIV,  W5,  S_P10, W1);
            7'd44: u = mk(U_MUL,  W6,  W4,    W0);
            7'd45: u = mk(U_ADD,  W6,  S_XP,  W6);
            7'd46: u = mk(U_STX,  D_POS, W6,  W6);
            7'd47: u = mk(U_MUL,  W7,  W5,    W0);
            7'd48: u = mk(U_ADD,  W7,  S_XV,  W7);
            7'd49: u = mk(U_STX,  D_VEL, W7,  W7);
            7'd50: u = mk(U_SUB,  W8,  S_ONE, W4);
            7'd51: u = mk(U_NEG,  W9,  W5,    W5);
            7'd52: u = mkj(U_BJ0, PC_STD);
            // Joseph form
            7'd53: u = mk(U_MUL,  W10, W8,    S_P00);
            7'd54: u = mk(U_MUL,  W11, W8,    S_P01);
            7'd55: u = mk(U_MUL,  W12, W9,    S_P00);
            7'd56: u = mk(U_ADD,  W12, W12,   S_P10);
            7'd57: u = mk(U_MUL,  W13, W9,    S_P01);
            7'd58: u = mk(U_ADD,  W13, W13,   S_P11);
            7'd59: u = mk(U_MUL,  W14, W4,    S_RN);
            7'd60: u = mk(U_MUL,  W15, W5,    S_RN);
            7'd61: u = mk(U_MUL,  W2,  W10,   W8);
            7'd62: u = mk(U_MUL,  W3,  W14,   W4);
            7'd63: u = mk(U_ADD,  W2,  W2,    W3);
            7'd64: u = mk(U_MUL,  W3,  W10,   W9);
            7'd65: u = mk(U_ADD,  W3,  W3,    W11);
            7'd66: u = mk(U_MUL,  W6,  W14,   W5);
            7'd67: u = mk(U_ADD,  W3,  W3,    W6);
            7'd68: u = mk(U_MUL,  W6,  W12,   W8);
            7'd69: u = mk(U_MUL,  W7,  W15,   W4);
            7'd70: u = mk(U_ADD,  W6,  W6,    W7);
            7'd71: u = mk(U_MUL,  W7,  W12,   W9);
            7'd72: u = mk(U_ADD,  W7,  W7,    W13);
            7'd73: u = mk(U_MUL,  W10, W15,   W5);
            7'd74: u = mk(U_ADD,  W7,  W7,    W10);
            7'd75: u = mk(U_STP,  D_P00, W2,  W2);
            7'd76: u = mk(U_STP,  D_P01, W3,  W3);
            7'd77: u = mk(U_STP,  D_P10, W6,  W6);
            7'd78: u = mk(U_STP,  D_P11, W7,  W7);
            7'd79: u = mkj(U_END, '0);
            // standard form
            7'd80: u = mk(U_MUL,  W2,  W8,    S_P00);
            7'd81: u = mk(U_MUL,  W3,  W8,    S_P01);
            7'd82: u = mk(U_MUL,  W6,  W9,    S_P00);
            7'd83: u = mk(U_ADD,  W6,  W6,    S_P10);
            7'd84: u = mk(U_MUL,  W7,  W9,    S_P01);
            7'd85: u = mk(U_ADD,  W7,  W7,    S_P11);
            7'd86: u = mkj(U_JMP, PC_STORE);
            default: u = mkj(U_END, '0);
        endcase
        return u;
    endfunction

    function automatic t_res f_sat_add(logic signed [WIDE-1:0] a, logic signed [WIDE-1:0] b);
        logic signed [WIDE:0] s;
        t_res r;
        s      = (WIDE+1)'(a) + (WIDE+1)'(b);
        r.v    = s[WIDE-1:0];
        r.clip = 1'b0;
        if (s > (WIDE+1)'(WIDE_MAX)) begin
            r.v    = WIDE_MAX;
            r.clip = 1'b1;
        end else if (s < -(WIDE+1)'(WIDE_MAX)) begin
            r.v    = -WIDE_MAX;
            r.clip = 1'b1;
        end
        return r;
    endfunction

    function automatic logic signed [WIDE-1:0] f_sat_neg(logic signed [WIDE-1:0] a);
        return (a == WIDE_MIN) ? WIDE_MAX : -a;
    endfunction

    // Covariance format back to Q16.16 with floor shift and 32-bit clamp
    function automatic t_res f_to_value(logic signed [WIDE-1:0] x);
        logic signed [WIDE-1:0] t;
        t_res r;
        t      = x >>> CONV_SHIFT;
        r.v    = t;
        r.clip = 1'b0;
        if (t > VAL_MAX) begin
            r.v    = VAL_MAX;
            r.clip = 1'b1;
        end else if (t < VAL_MIN) begin
            r.v    = VAL_MIN;
            r.clip = 1'b1;
        end
        return r;
    endfunction

    function automatic t_res f_clamp_cov(logic signed [WIDE-1:0] x);
        t_res r;
        r.v    = x;
        r.clip = 1'b0;
        if (x > COV_MAX) begin
            r.v    = COV_MAX;
            r.clip = 1'b1;
        end else if (x < COV_MIN) begin
            r.v    = COV_MIN;
            r.clip = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/kfpv_mul.sv
// Sequential fixed-point multiplier: 64x64 magnitude product from four
// 32x32 partial products, scaled by COV_FRAC_BITS and saturated. Uses kfpv_pkg.
`default_nettype none

module kfpv_mul import kfpv_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic signed [WIDE-1:0] i_a,
    input  wire logic signed [WIDE-1:0] i_b,
    output logic                        o_done,
    output t_res                        o_res
);

    logic [WIDE-1:0]   r_ua, r_ub;
    logic              r_neg;
    logic [2*WIDE-1:0] r_acc;
    logic [1:0]        r_cnt;
    logic              r_busy, r_done;

    logic [31:0]       w_pa, w_pb;
    logic [63:0]       w_pp;
    logic [1:0]        w_sel;
    logic [2*WIDE-1:0] w_term, w_shr;
    logic              w_ovf;
    logic [WIDE-1:0]   w_mag;

    always_comb begin
        w_pa   = r_cnt[1] ? r_ua[63:32] : r_ua[31:0];
        w_pb   = r_cnt[0] ? r_ub[63:32] : r_ub[31:0];
        w_pp   = w_pa * w_pb;
        w_sel  = 2'(r_cnt[1]) + 2'(r_cnt[0]);
        w_term = {64'b0, w_pp} << {w_sel, 5'b0};
        w_shr  = r_acc >> COV_FRAC_BITS;
        w_ovf  = |w_shr[2*WIDE-1:WIDE-1];
        w_mag  = w_ovf ? WIDE_MAX : w_shr[WIDE-1:0];
        o_res.v    = r_neg ? -w_mag : w_mag;
        o_res.clip = w_ovf;
        o_done     = r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua  <= i_a[WIDE-1] ? -i_a : i_a;
            r_ub  <= i_b[WIDE-1] ? -i_b : i_b;
            r_neg <= i_a[WIDE-1] ^ i_b[WIDE-1];
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_term;
        end
    end

endmodule

`default_nettype wire

### src/kfpv_div.sv
// Bit-serial restoring divider: (|p| << COV_FRAC_BITS) / s, one quotient bit
// per cycle, truncating toward zero and saturating. Uses kfpv_pkg.
`default_nettype none

module kfpv_div import kfpv_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic signed [WIDE-1:0] i_a,
    input  wire logic signed [WIDE-1:0] i_b,
    output logic                        o_done,
    output t_res                        o_res
);

    logic [DIV_BITS-1:0]  r_num, r_q;
    logic [WIDE-1:0]      r_den, r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg, r_busy, r_done;

    logic [WIDE:0]        w_rsh, w_rnx;
    logic                 w_ge, w_ovf;
    logic [WIDE-1:0]      w_mag, w_ua;

    always_comb begin
        w_ua  = i_a[WIDE-1] ? -i_a : i_a;
        w_rsh = {r_rem, r_num[DIV_BITS-1]};
        w_ge  = w_rsh >= {1'b0, r_den};
        w_rnx = w_ge ? (w_rsh - {1'b0, r_den}) : w_rsh;
        w_ovf = |r_q[DIV_BITS-1:WIDE-1];
        w_mag = w_ovf ? WIDE_MAX : {1'b0, r_q[WIDE-2:0]};
        o_res.v    = r_neg ? -w_mag : w_mag;
        o_res.clip = w_ovf;
        o_done     = r_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {w_ua, COV_FRAC_BITS'(0)};
            r_den <= i_b;
            r_rem <= '0;
            r_q   <= '0;
            r_neg <= i_a[WIDE-1];
        end else if (r_busy) begin
            r_num <= r_num << 1;
            r_rem <= w_rnx[WIDE-1:0];
            r_q   <= {r_q[DIV_BITS-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

### src/kalman_filter_pos_vel.sv
// Two-state position/velocity Kalman filter, top level with micro-sequencer.
// Uses kfpv_pkg, kfpv_mul and kfpv_div.
//
// One input transaction runs a short micro-program over a 16-entry scratch
// memory, with one shared multiplier (four 32x32 partial products), one
// bit-serial divider and a saturating adder. A correct runs in Joseph or in
// standard form and stops early when the gate rejects; reset and the unused
// op run no micro-program. The input is not ready while a transaction is in
// work. The result sits in an output register, so a new item is taken while
// it waits.
`default_nettype none

module kalman_filter_pos_vel import kfpv_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // value_a[31:0], value_b[63:32]
    input  wire logic [1:0]  s_axis_tuser,   // op[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // position[31:0], velocity[63:32]
    output logic [1:0]       m_axis_tuser,   // accepted[0], saturated[1]
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FETCH = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic r_wait, n_wait;
    logic r_ok, r_clip;

    logic [31:0] r_dt, r_qa, r_rn, r_gs;
    logic        r_jm;
    logic signed [31:0] r_pos, r_vel, r_za;
    logic signed [COV_WIDTH-1:0] r_p00, r_p01, r_p10, r_p11;

    logic signed [WIDE-1:0] r_w [16];
    logic signed [WIDE-1:0] r_opa, r_opb;
    logic signed [WIDE-1:0] w_spec [16];

    logic        r_m_valid;
    logic [63:0] r_m_data;
    logic [1:0]  r_m_user;

    t_uins w_ins;
    t_res  w_res, w_mres, w_dres, w_tv, w_tc;
    logic  w_in_acc, w_mul_go, w_div_go, w_mul_done, w_div_done;
    logic  w_we, w_stx, w_stp, w_end, w_rej, w_load;

    kfpv_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_go),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .o_done  (w_mul_done),
        .o_res   (w_mres)
    );

    kfpv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_go),
        .i_a     (r_opa),
        .i_b     (r_opb),
        .o_done  (w_div_done),
        .o_res   (w_dres)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign w_ins         = f_prog(r_pc);
    assign w_load        = (r_state == ST_DONE) && (!r_m_valid || m_axis_tready);

    // Operands in covariance format
    always_comb begin
        for (int i = 0; i < 16; i++) begin
            w_spec[i] = '0;
        end
        w_spec[S_DT[3:0]]  = WIDE'(r_dt) <<< CONV_SHIFT;
        w_spec[S_QA[3:0]]  = WIDE'(r_qa) <<< CONV_SHIFT;
        w_spec[S_RN[3:0]]  = WIDE'(r_rn) <<< CONV_SHIFT;
        w_spec[S_GS[3:0]]  = WIDE'(r_gs) <<< CONV_SHIFT;
        w_spec[S_XP[3:0]]  = WIDE'(r_pos) <<< CONV_SHIFT;
        w_spec[S_XV[3:0]]  = WIDE'(r_vel) <<< CONV_SHIFT;
        w_spec[S_Z[3:0]]   = WIDE'(r_za) <<< CONV_SHIFT;
        w_spec[S_P00[3:0]] = WIDE'(r_p00);
        w_spec[S_P01[3:0]] = WIDE'(r_p01);
        w_spec[S_P10[3:0]] = WIDE'(r_p10);
        w_spec[S_P11[3:0]] = WIDE'(r_p11);
        w_spec[S_ONE[3:0]] = ONE_COV;
    end

    // Shared arithmetic result
    always_comb begin
        w_res.v    = r_opa;
        w_res.clip = 1'b0;
        case (w_ins.op)
            U_MUL:  w_res = w_mres;
            U_DIV:  w_res = w_dres;
            U_ADD:  w_res = f_sat_add(r_opa, r_opb);
            U_SUB:  w_res = f_sat_add(r_opa, f_sat_neg(r_opb));
            U_NEG:  w_res.v = f_sat_neg(r_opa);
            U_SHR1: w_res.v = r_opa >>> 1;
            U_SHR2: w_res.v = r_opa >>> 2;
            U_MAX1: w_res.v = (r_opa < 64'sd1) ? 64'sd1 : r_opa;
            default: w_res.v = r_opa;
        endcase
        w_tv = f_to_value(r_opa);
        w_tc = f_clamp_cov(r_opa);
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_wait   = r_wait;
        w_mul_go = 1'b0;
        w_div_go = 1'b0;
        w_we     = 1'b0;
        w_stx    = 1'b0;
        w_stp    = 1'b0;
        w_end    = 1'b0;
        w_rej    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == OP_PREDICT) begin
                        n_pc    = PC_PREDICT;
                        n_state = ST_FETCH;
                    end else if (s_axis_tuser == OP_CORRECT) begin
                        n_pc    = PC_CORRECT;
                        n_state = ST_FETCH;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_FETCH: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_FETCH;
                n_pc    = r_pc + 1'b1;
                unique case (w_ins.op)
                    U_MUL, U_DIV: begin
                        if (!r_wait) begin
                            n_wait   = 1'b1;
                            w_mul_go = (w_ins.op == U_MUL);
                            w_div_go = (w_ins.op == U_DIV);
                            n_state  = ST_EXEC;
                            n_pc     = r_pc;
                        end else if (w_mul_done || w_div_done) begin
                            n_wait = 1'b0;
                            w_we   = 1'b1;
                        end else begin
                            n_state = ST_EXEC;
                            n_pc    = r_pc;
                        end
                    end
                    U_ADD, U_SUB, U_NEG, U_SHR1, U_SHR2, U_MAX1: w_we = 1'b1;
                    U_STX: w_stx = 1'b1;
                    U_STP: w_stp = 1'b1;
                    U_BGZ: begin
                        if (r_gs == '0) begin
                            n_pc = w_ins.tgt;
                        end
                    end
                    U_BJ0: begin
                        if (!r_jm) begin
                            n_pc = w_ins.tgt;
                        end
                    end
                    U_JMP: n_pc = w_ins.tgt;
                    U_GATE: begin
                        if (r_opa > r_opb) begin
                            w_rej   = 1'b1;
                            n_state = ST_DONE;
                        end
                    end
                    U_END: begin
                        w_end   = 1'b1;
                        n_state = ST_DONE;
                    end
                    default: n_state = ST_DONE;
                endcase
            end
            ST_DONE: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pc      <= '0;
            r_wait    <= 1'b0;
            r_ok      <= 1'b0;
            r_clip    <= 1'b0;
            r_m_valid <= 1'b0;
            r_dt      <= 32'd655;
            r_qa      <= 32'd65536;
            r_rn      <= 32'd65536;
            r_gs      <= '0;
            r_jm      <= 1'b1;
            r_pos     <= '0;
            r_vel     <= '0;
            r_p00     <= COV_INIT;
            r_p01     <= '0;
            r_p10     <= '0;
            r_p11     <= COV_INIT;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_wait    <= n_wait;
            r_m_valid <= (r_m_valid && !m_axis_tready) || w_load;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DT:  r_dt <= i_cfg_wdata;
                    CFG_QA:  r_qa <= i_cfg_wdata;
                    CFG_RN:  r_rn <= i_cfg_wdata;
                    CFG_GS:  r_gs <= i_cfg_wdata;
                    CFG_JM:  r_jm <= i_cfg_wdata[0];
                    default: ;
                endcase
            end

            if (w_in_acc) begin
                r_clip <= 1'b0;
                r_ok   <= (s_axis_tuser == OP_RESET);
                if (s_axis_tuser == OP_RESET) begin
                    r_pos <= s_axis_tdata[31:0];
                    r_vel <= s_axis_tdata[63:32];
                    r_p00 <= COV_INIT;
                    r_p01 <= '0;
                    r_p10 <= '0;
                    r_p11 <= COV_INIT;
                end
            end else begin
                if (w_end) begin
                    r_ok <= 1'b1;
                end
                if (w_rej) begin
                    r_ok <= 1'b0;
                end
                if (w_we) begin
                    r_clip <= r_clip | w_res.clip;
                end
                if (w_stx) begin
                    r_clip <= r_clip | w_tv.clip;
                    if (w_ins.dst == D_POS) begin
                        r_pos <= w_tv.v[31:0];
                    end else begin
                        r_vel <= w_tv.v[31:0];
                    end
                end
                if (w_stp) begin
                    r_clip <= r_clip | w_tc.clip;
                    unique case (w_ins.dst)
                        D_P00:   r_p00 <= w_tc.v[COV_WIDTH-1:0];
                        D_P01:   r_p01 <= w_tc.v[COV_WIDTH-1:0];
                        D_P10:   r_p10 <= w_tc.v[COV_WIDTH-1:0];
                        default: r_p11 <= w_tc.v[COV_WIDTH-1:0];
                    endcase
                end
            end
        end
    end

    // Payload: input latch, scratch memory, operand read, output register
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_za <= s_axis_tdata[31:0];
        end
        if (w_we) begin
            r_w[w_ins.dst[3:0]] <= w_res.v;
        end
        if (r_state == ST_FETCH) begin
            r_opa <= w_ins.a[4] ? w_spec[w_ins.a[3:0]] : r_w[w_ins.a[3:0]];
            r_opb <= w_ins.b[4] ? w_spec[w_ins.b[3:0]] : r_w[w_ins.b[3:0]];
        end
        if (w_load) begin
            r_m_data <= {r_vel, r_pos};
            r_m_user <= {r_clip, r_ok};
        end
    end

endmodule

`default_nettype wire

### tb/kfpv_checker.sv
// Checker for the position/velocity Kalman filter: watches the config port and
// both streams, predicts each result in fixed point and compares it.
// Depends on kfpv_pkg for the operation codes, register indexes and format shifts.
module kfpv_checker import kfpv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint CLAMP_LIM = (64'sd1 <<< 47) - 1;

    typedef struct {
        bit     accepted;
        bit     saturated;
        logic [31:0] position;
        logic [31:0] velocity;
    } t_filt_out;

    t_filt_out   est_q[$];
    longint      dt_reg, qa_reg, rn_reg, gs_reg;
    bit          joseph_reg;
    longint      pos_est, vel_est, p00, p01, p10, p11;
    bit          clip_seen;

    function automatic longint sadd(longint a, longint b);
        if (b > 0 && a > SAT_MAX - b) begin
            clip_seen = 1;
            return SAT_MAX;
        end
        if (b < 0 && a < -SAT_MAX - b) begin
            clip_seen = 1;
            return -SAT_MAX;
        end
        return a + b;
    endfunction

    function automatic longint sneg(longint a);
        return (a < -SAT_MAX) ? SAT_MAX : -a;
    endfunction

    function automatic longint fmul(longint a, longint b);
        logic [63:0]  ua, ub, lo;
        logic [127:0] p;
        bit           neg;
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        neg = (a < 0) != (b < 0);
        p   = ({64'd0, ua} * {64'd0, ub}) >> COV_FRAC_BITS;
        lo  = p[63:0];
        if (p[127:63] != 0) begin
            clip_seen = 1;
            lo = SAT_MAX;
        end
        return neg ? -longint'(lo) : longint'(lo);
    endfunction

    // divisor is at least one LSB
    function automatic longint fdiv(longint num, longint den);
        logic [63:0]  un, lo;
        logic [127:0] q;
        un = (num < 0) ? -num : num;
        q  = ({64'd0, un} << COV_FRAC_BITS) / {64'd0, den};
        lo = q[63:0];
        if (q[127:63] != 0) begin
            clip_seen = 1;
            lo = SAT_MAX;
        end
        return (num < 0) ? -longint'(lo) : longint'(lo);
    endfunction

    function automatic longint cclamp(longint x);
        if (x > CLAMP_LIM) begin
            clip_seen = 1;
            return CLAMP_LIM;
        end
        if (x < -CLAMP_LIM - 1) begin
            clip_seen = 1;
            return -CLAMP_LIM - 1;
        end
        return x;
    endfunction

    function automatic longint widen(longint x);
        return x <<< CONV_SHIFT;
    endfunction

    function automatic longint narrow(longint x);
        longint t;
        t = x >>> CONV_SHIFT;
        if (t > 64'sd2147483647) begin
            clip_seen = 1;
            return 64'sd2147483647;
        end
        if (t < -64'sd2147483648) begin
            clip_seen = 1;
            return -64'sd2147483648;
        end
        return t;
    endfunction

    function automatic void load_cov();
        p00 = cclamp(64'sd1000 <<< COV_FRAC_BITS);
        p01 = 0;
        p10 = 0;
        p11 = cclamp(64'sd1000 <<< COV_FRAC_BITS);
    endfunction

    function automatic void run_predict(longint u_raw);
        longint dt, qa, x, v, u, dt2, dt3, dt4, q00, q01, q11, g0, f00, f01, f10, f11;
        dt  = widen(dt_reg);
        qa  = widen(qa_reg);
        x   = widen(pos_est);
        v   = widen(vel_est);
        u   = widen(u_raw);
        dt2 = fmul(dt, dt);
        dt3 = fmul(dt2, dt);
        dt4 = fmul(dt2, dt2);
        q00 = fmul(dt4, qa) >>> 2;
        q01 = fmul(dt3, qa) >>> 1;
        q11 = fmul(dt2, qa);
        g0  = dt2 >>> 1;
        x   = sadd(sadd(x, fmul(dt, v)), fmul(g0, u));
        v   = sadd(v, fmul(dt, u));
        pos_est = narrow(x);
        vel_est = narrow(v);
        f00 = sadd(p00, fmul(dt, p10));
        f01 = sadd(p01, fmul(dt, p11));
        f10 = p10;
        f11 = p11;
        p00 = cclamp(sadd(sadd(f00, fmul(f01, dt)), q00));
        p01 = cclamp(sadd(f01, q01));
        p10 = cclamp(sadd(sadd(f10, fmul(f11, dt)), q01));
        p11 = cclamp(sadd(f11, q11));
    endfunction

    function automatic bit run_correct(longint z_raw);
        longint r, y, s, g, k0, k1, a, nk1, o00, o01, o10, o11;
        longint t00, t01, t10, t11, k0r, k1r;
        r = widen(rn_reg);
        y = sadd(widen(z_raw), sneg(widen(pos_est)));
        s = sadd(p00, r);
        if (s < 1) s = 1;
        if (gs_reg != 0) begin
            g = widen(gs_reg);
            if (fmul(y, y) > fmul(fmul(g, g), s)) return 0;
        end
        k0 = fdiv(p00, s);
        k1 = fdiv(p10, s);
        pos_est = narrow(sadd(widen(pos_est), fmul(k0, y)));
        vel_est = narrow(sadd(widen(vel_est), fmul(k1, y)));
        a   = sadd(64'sd1 <<< COV_FRAC_BITS, sneg(k0));
        nk1 = sneg(k1);
        o00 = p00; o01 = p01; o10 = p10; o11 = p11;
        if (joseph_reg) begin
            t00 = fmul(a, o00);
            t01 = fmul(a, o01);
            t10 = sadd(fmul(nk1, o00), o10);
            t11 = sadd(fmul(nk1, o01), o11);
            k0r = fmul(k0, r);
            k1r = fmul(k1, r);
            p00 = cclamp(sadd(fmul(t00, a), fmul(k0r, k0)));
            p01 = cclamp(sadd(sadd(fmul(t00, nk1), t01), fmul(k0r, k1)));
            p10 = cclamp(sadd(fmul(t10, a), fmul(k1r, k0)));
            p11 = cclamp(sadd(sadd(fmul(t10, nk1), t11), fmul(k1r, k1)));
        end else begin
            p00 = cclamp(fmul(a, o00));
            p01 = cclamp(fmul(a, o01));
            p10 = cclamp(sadd(fmul(nk1, o00), o10));
            p11 = cclamp(sadd(fmul(nk1, o01), o11));
        end
        return 1;
    endfunction

    function automatic t_filt_out filter_step(logic [1:0] op, logic [31:0] va,
                                              logic [31:0] vb);
        t_filt_out res;
        bit        ok;
        ok        = 1;
        clip_seen = 0;
        case (op)
            OP_PREDICT: run_predict(longint'(signed'(va)));
            OP_CORRECT: ok = run_correct(longint'(signed'(va)));
            OP_RESET: begin
                pos_est = longint'(signed'(va));
                vel_est = longint'(signed'(vb));
                load_cov();
            end
            default: ok = 0;
        endcase
        res.accepted  = ok;
        res.saturated = clip_seen;
        res.position  = pos_est[31:0];
        res.velocity  = vel_est[31:0];
        return res;
    endfunction

    assign o_pending = est_q.size();

    always @(posedge i_clk) begin
        t_filt_out want;
        if (!i_rst_n) begin
            dt_reg     = 655;
            qa_reg     = 65536;
            rn_reg     = 65536;
            gs_reg     = 0;
            joseph_reg = 1;
            pos_est    = 0;
            vel_est    = 0;
            load_cov();
            est_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DT: dt_reg = longint'({32'd0, i_cfg_wdata});
                    CFG_QA: qa_reg = longint'({32'd0, i_cfg_wdata});
                    CFG_RN: rn_reg = longint'({32'd0, i_cfg_wdata});
                    CFG_GS: gs_reg = longint'({32'd0, i_cfg_wdata});
                    CFG_JM: joseph_reg = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                est_q.push_back(filter_step(s_axis_tuser, s_axis_tdata[31:0],
                                            s_axis_tdata[63:32]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (est_q.size() == 0) begin
                    $display("%0t: unexpected result tdata=%h tuser=%b", $time,
                             m_axis_tdata, m_axis_tuser);
                    o_errors <= o_errors + 1;
                end else begin
                    want = est_q.pop_front();
                    if (m_axis_tuser[0] !== want.accepted
                        || m_axis_tuser[1] !== want.saturated
                        || m_axis_tdata[31:0] !== want.position
                        || m_axis_tdata[63:32] !== want.velocity) begin
                        $display("%0t: mismatch expected acc=%b sat=%b pos=%h vel=%h",
                                 $time, want.accepted, want.saturated,
                                 want.position, want.velocity);
                        $display("%0t:          actual   acc=%b sat=%b pos=%h vel=%h",
                                 $time, m_axis_tuser[0], m_axis_tuser[1],
                                 m_axis_tdata[31:0], m_axis_tdata[63:32]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

### tb/kalman_filter_pos_vel_tb.sv
// Top of the Kalman filter testbench: clock, reset, config phases and stimulus.
// Depends on kfpv_pkg, the kalman_filter_pos_vel block and kfpv_checker.
module kalman_filter_pos_vel_tb import kfpv_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int         RAND_ITEMS = 190;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [63:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [31:0] i_cfg_wdata = '0;
    int          fail_cnt;
    int          pending;
    bit          long_hold_req = 0;

    kalman_filter_pos_vel uut (.*);

    kfpv_checker chk (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .m_axis_tuser, .i_cfg_we, .i_cfg_idx, .i_cfg_wdata,
        .o_errors(fail_cnt), .o_pending(pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #60_000_000;
        $display("kalman_filter_pos_vel_tb failed");
        $finish;
    end

    // Result side: random back-pressure, short stalls, and one long hold-off on request
    initial begin
        int hold;
        int r;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 0;
                hold = 3000;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 2) hold = $urandom_range(20, 400);
                m_axis_tready <= (r >= 25);
            end
        end
    end

    // Drive one transaction starting at a falling edge, return at a falling edge
    task automatic send_item(logic [1:0] op, logic [31:0] va, logic [31:0] vb);
        int r;
        s_axis_tvalid <= 1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {vb, va};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        r = $urandom_range(0, 99);
        if (r >= 60) begin
            s_axis_tvalid <= 0;
            repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(20, 300))
                @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_we    <= 1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 0;
        @(negedge i_clk);
    endtask

    // Hold until every result is back and the sequencer has settled
    task automatic drain();
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 3) == 0) return $urandom();
        return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
    endfunction

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) send_item(OP_RESET, pick_value(), pick_value());
        else if (r < 52) send_item(OP_PREDICT, pick_value(), $urandom());
        else if (r < 96) send_item(OP_CORRECT, pick_value(), $urandom());
        else send_item(OP_UNUSED, $urandom(), $urandom());
    endtask

    initial begin
        logic [31:0] dt_set[6] = '{32'd655, 32'd1, 32'd65536, 32'hFFFF_FFFF, 32'd3277, 32'd0};
        logic [31:0] qa_set[6] = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd6554, 32'd1, 32'd0};
        logic [31:0] rn_set[6] = '{32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd655360, 32'd0};
        logic [31:0] gs_set[6] = '{32'd0, 32'h0003_0000, 32'hFFFF_FFFF, 32'h0001_0000,
                                   32'd0, 32'd1};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: field extremes, every op, gate rejection, saturation
        send_item(OP_PREDICT, 32'd0, 32'd0);
        send_item(OP_CORRECT, 32'h0001_0000, 32'd0);
        send_item(OP_RESET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_PREDICT, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_CORRECT, 32'h8000_0000, 32'd0);
        send_item(OP_RESET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_PREDICT, 32'h8000_0000, 32'd0);
        send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_RESET, 32'd0, 32'd0);
        drain();
        write_reg(CFG_GS, 32'h0001_0000);
        write_reg(CFG_RN, 32'd0);
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        send_item(OP_CORRECT, 32'h0100_0000, 32'd0);
        send_item(OP_CORRECT, 32'h0000_8000, 32'd0);
        send_item(OP_CORRECT, 32'h7FFF_FFFF, 32'd0);
        drain();
        write_reg(CFG_JM, 32'd0);
        write_reg(CFG_DT, 32'hFFFF_FFFF);
        write_reg(CFG_QA, 32'hFFFF_FFFF);
        send_item(OP_PREDICT, 32'h7FFF_FFFF, 32'd0);
        send_item(OP_CORRECT, 32'h8000_0000, 32'd0);
        send_item(OP_RESET, 32'h1234_5678, 32'h8765_4321);
        send_item(OP_CORRECT, 32'h0001_0000, 32'd0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_DT, dt_set[ph]);
            write_reg(CFG_QA, qa_set[ph]);
            write_reg(CFG_RN, rn_set[ph]);
            write_reg(CFG_GS, gs_set[ph]);
            write_reg(CFG_JM, {31'd0, ph[0]});
            if (ph == 1) long_hold_req = 1;
            send_item(OP_RESET, pick_value(), pick_value());
            for (int n = 0; n < RAND_ITEMS; n++) random_item();
            drain();
        end

        repeat (100) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("kalman_filter_pos_vel_tb passed");
        else
            $display("kalman_filter_pos_vel_tb failed");
        $finish;
    end
endmodule
